// ===== sv/imu_sample_calibrate_and_smooth_macros.svh =====
// Assertion macros shared by the IMU calibrate and smooth block.
`ifndef IMU_SAMPLE_CALIBRATE_AND_SMOOTH_MACROS_SVH
`define IMU_SAMPLE_CALIBRATE_AND_SMOOTH_MACROS_SVH

// same-cycle implication, off during reset
`define IMU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define IMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/imu_scs_pkg.sv =====
// Shared types and constants of the IMU calibrate and smooth block.
`timescale 1ns / 1ps

package imu_scs_pkg;

   localparam int CHANNELS   = 9;
   localparam int MOTION_CH  = 6;
   localparam int MAG_CH     = 3;
   localparam int DATA_W     = 16;
   localparam int SENS_W     = 9;
   localparam int MAG_PROD_W = DATA_W + SENS_W + 1;
   localparam int MAG_SHIFT  = 8;
   localparam int ACC_Z_LANE = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [SENS_W-1:0]        SENS_RESET   = 9'd256;
   localparam logic signed [DATA_W-1:0] ONE_G_COUNTS = 16'sd8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAG_SENS_X   = 3'd0,
      CSR_MAG_SENS_Y   = 3'd1,
      CSR_MAG_SENS_Z   = 3'd2,
      CSR_MAG_OFFSET_X = 3'd3,
      CSR_MAG_OFFSET_Y = 3'd4,
      CSR_MAG_OFFSET_Z = 3'd5
   } csr_index_type;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef sample_type [CHANNELS-1:0]  sample_vec_type;
   typedef sample_type [MOTION_CH-1:0] motion_vec_type;

   typedef struct packed {
      sample_type acc_x;
      sample_type acc_y;
      sample_type acc_z;
      sample_type gyro_x;
      sample_type gyro_y;
      sample_type gyro_z;
      sample_type mag_x;
      sample_type mag_y;
      sample_type mag_z;
      logic       mag_ready;
      logic       mag_overrun;
      logic       mag_overflow;
   } req_type;

   typedef struct packed {
      sample_type avg_acc_x;
      sample_type avg_acc_y;
      sample_type avg_acc_z;
      sample_type avg_gyro_x;
      sample_type avg_gyro_y;
      sample_type avg_gyro_z;
      sample_type avg_mag_x;
      sample_type avg_mag_y;
      sample_type avg_mag_z;
      logic       calibrated;
   } rsp_type;

   // per-word flags carried down the averaging pipe
   typedef struct packed {
      logic full;
      logic calibrated;
   } item_flags_type;

   // calibration unit status towards the top level
   typedef struct packed {
      logic done;
      logic busy;
      logic last;
   } cal_status_type;

endpackage

// ===== sv/imu_scs_if.sv =====
// Valid/ready channel interfaces for sample frames and smoothed results.
`timescale 1ns / 1ps

interface imu_scs_req_if;
   logic                  valid;
   logic                  ready;
   imu_scs_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface imu_scs_rsp_if;
   logic                  valid;
   logic                  ready;
   imu_scs_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/imu_scs_win_mem.sv =====
// Window sample memory: one row of all channels per ring position.
`timescale 1ns / 1ps

module imu_scs_win_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 144
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/imu_scs_cal.sv =====
// Startup calibration: frame sums, reciprocal divide and motion offsets.
`timescale 1ns / 1ps

module imu_scs_cal #(
   parameter int CAL_FRAMES = 100
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  imu_scs_pkg::motion_vec_type motion,
   output imu_scs_pkg::motion_vec_type offsets,
   output imu_scs_pkg::cal_status_type status
);

   localparam int DATA_W = imu_scs_pkg::DATA_W;
   localparam int LANES  = imu_scs_pkg::MOTION_CH;
   localparam int LOG_N  = $clog2(CAL_FRAMES);
   localparam int CNT_W  = (CAL_FRAMES > 1) ? LOG_N : 1;
   localparam int SUM_W  = DATA_W + LOG_N;
   localparam int RW     = SUM_W + 1;
   localparam int PW     = SUM_W + RW;
   localparam int K      = SUM_W + LOG_N;

   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(CAL_FRAMES - 1);

   // ceiling reciprocal, exact for every magnitude below 2^SUM_W
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << K) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

   typedef enum logic [2:0] {ACCUM, LOAD, SCALE, WRITE, DONE} state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [LANES-1:0][SUM_W-1:0]   sum_ff,  sum_in;
   logic [LANES-1:0][SUM_W-1:0]   mag_ff;
   logic [LANES-1:0][DATA_W-1:0]  quo_ff,  quo_in;
   logic [LANES-1:0]              neg_ff;
   imu_scs_pkg::motion_vec_type   offset_ff, offset_in;
   logic [LANES-1:0][PW-1:0]      prod;
   logic [LANES-1:0][DATA_W-1:0]  avg;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sum_in[i] = sum_ff[i] + SUM_W'($signed(motion[i]));
         // magnitude times the reciprocal; the quotient sits K bits up
         prod[i]   = PW'(mag_ff[i]) * PW'(RECIP);
         quo_in[i] = prod[i][K +: DATA_W];
         avg[i]    = neg_ff[i] ? -quo_ff[i] : quo_ff[i];
         if (i == imu_scs_pkg::ACC_Z_LANE) begin
            offset_in[i] = imu_scs_pkg::ONE_G_COUNTS - $signed(avg[i]);
         end else begin
            offset_in[i] = avg[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ACCUM;
         count_ff  <= '0;
         sum_ff    <= '0;
         mag_ff    <= '0;
         quo_ff    <= '0;
         neg_ff    <= '0;
         offset_ff <= '0;
      end else begin
         unique case (state_ff)
            ACCUM: begin
               if (take) begin
                  sum_ff <= sum_in;
                  if (count_ff == LAST_COUNT) begin
                     count_ff <= '0;
                     state_ff <= LOAD;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            LOAD: begin
               for (int i = 0; i < LANES; i++) begin
                  neg_ff[i] <= sum_ff[i][SUM_W-1];
                  mag_ff[i] <= sum_ff[i][SUM_W-1] ? -sum_ff[i] : sum_ff[i];
               end
               sum_ff   <= '0;
               state_ff <= SCALE;
            end
            SCALE: begin
               quo_ff   <= quo_in;
               state_ff <= WRITE;
            end
            WRITE: begin
               offset_ff <= offset_in;
               state_ff  <= DONE;
            end
            DONE: begin
               state_ff <= DONE;
            end
            default: begin
               state_ff <= ACCUM;
            end
         endcase
      end
   end

   assign offsets     = offset_ff;
   assign status.done = (state_ff != ACCUM);
   assign status.busy = (state_ff == LOAD) || (state_ff == SCALE) || (state_ff == WRITE);
   assign status.last = take && (state_ff == ACCUM) && (count_ff == LAST_COUNT);

endmodule

// ===== sv/imu_scs_avg.sv =====
// Window average divide pipe and result register.
`timescale 1ns / 1ps

module imu_scs_avg #(
   parameter int WINDOW_LEN = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [imu_scs_pkg::CHANNELS-1:0]
                [imu_scs_pkg::DATA_W+$clog2(WINDOW_LEN)-1:0] in_sums,
   input  imu_scs_pkg::sample_vec_type        in_samples,
   input  imu_scs_pkg::item_flags_type        in_flags,
   imu_scs_rsp_if.source                      rsp
);

   localparam int CH     = imu_scs_pkg::CHANNELS;
   localparam int DATA_W = imu_scs_pkg::DATA_W;
   localparam int LOG_L  = $clog2(WINDOW_LEN);
   localparam int SUM_W  = DATA_W + LOG_L;
   localparam int RW     = SUM_W + 1;
   localparam int PW     = SUM_W + RW;
   localparam int K      = SUM_W + LOG_L;

   // ceiling reciprocal, exact for every magnitude below 2^SUM_W
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

   logic                         p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic                         p1_take, p2_take, p3_take;
   logic [CH-1:0][SUM_W-1:0]     p1_mag_ff,  p1_mag_in;
   logic [CH-1:0]                p1_neg_ff,  p2_neg_ff;
   imu_scs_pkg::sample_vec_type  p1_samp_ff, p2_samp_ff;
   imu_scs_pkg::item_flags_type  p1_flags_ff, p2_flags_ff;
   logic [CH-1:0][PW-1:0]        prod;
   logic [CH-1:0][DATA_W-1:0]    p2_quo_ff, p2_quo_in;
   imu_scs_pkg::sample_vec_type  res_ff, res_in;
   logic                         cal_ff;

   assign p3_take  = p2_valid_ff && (!p3_valid_ff || rsp.ready);
   assign p2_take  = p1_valid_ff && (!p2_valid_ff || p3_take);
   assign p1_take  = in_valid && in_ready;
   assign in_ready = !p1_valid_ff || p2_take;

   always_comb begin
      for (int i = 0; i < CH; i++) begin
         p1_mag_in[i] = in_sums[i][SUM_W-1] ? -in_sums[i] : in_sums[i];
         prod[i]      = PW'(p1_mag_ff[i]) * PW'(RECIP);
         p2_quo_in[i] = prod[i][K +: DATA_W];
         if (p2_flags_ff.full) begin
            res_in[i] = p2_neg_ff[i] ? -p2_quo_ff[i] : p2_quo_ff[i];
         end else begin
            res_in[i] = p2_samp_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         if (p1_take) begin
            p1_valid_ff <= 1'b1;
         end else if (p2_take) begin
            p1_valid_ff <= 1'b0;
         end
         if (p2_take) begin
            p2_valid_ff <= 1'b1;
         end else if (p3_take) begin
            p2_valid_ff <= 1'b0;
         end
         if (p3_take) begin
            p3_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            p3_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_take) begin
         p1_mag_ff   <= p1_mag_in;
         for (int i = 0; i < CH; i++) begin
            p1_neg_ff[i] <= in_sums[i][SUM_W-1];
         end
         p1_samp_ff  <= in_samples;
         p1_flags_ff <= in_flags;
      end
      if (p2_take) begin
         p2_quo_ff   <= p2_quo_in;
         p2_neg_ff   <= p1_neg_ff;
         p2_samp_ff  <= p1_samp_ff;
         p2_flags_ff <= p1_flags_ff;
      end
      if (p3_take) begin
         res_ff <= res_in;
         cal_ff <= p2_flags_ff.calibrated;
      end
   end

   assign rsp.valid           = p3_valid_ff;
   assign rsp.data.avg_acc_x  = res_ff[0];
   assign rsp.data.avg_acc_y  = res_ff[1];
   assign rsp.data.avg_acc_z  = res_ff[2];
   assign rsp.data.avg_gyro_x = res_ff[3];
   assign rsp.data.avg_gyro_y = res_ff[4];
   assign rsp.data.avg_gyro_z = res_ff[5];
   assign rsp.data.avg_mag_x  = res_ff[6];
   assign rsp.data.avg_mag_y  = res_ff[7];
   assign rsp.data.avg_mag_z  = res_ff[8];
   assign rsp.data.calibrated = cal_ff;

endmodule

// ===== sv/imu_sample_calibrate_and_smooth.sv =====
// Top level: IMU frame correction, startup calibration and window smoothing.
`timescale 1ns / 1ps
//
// req_bus takes one word per frame: nine raw 16-bit samples (accel, gyro,
// magnetometer) and the three magnetometer status bits. rsp_bus returns one
// word per frame: nine smoothed channels and the calibrated flag.
// csr_* writes the magnetometer gain and hard-iron offset registers; write
// them only while no frame is in flight.
// Latency: a frame passes the stage A register, then the p1, p2 and result
// registers of the divide pipe before it shows on rsp_bus.
// Throughput: one frame per cycle while rsp_bus takes words and calibration is
// not busy, set by the window memory, which is read when a frame is accepted and
// written back one stage later; consecutive frames always use different ring rows.
// Once only, after the last calibration frame, req_bus.ready stays low through the
// LOAD, SCALE and WRITE states while the reciprocal multiply produces the motion offsets.
// Reset (synchronous, active high) empties the pipe, restarts calibration
// and the ring; stale memory rows are ignored until the ring first wraps,
// so no clearing pass is needed.
// A stalled rsp_bus holds its word; the four stages keep filling, and
// req_bus.ready falls only once every stage holds a frame.
//
module imu_sample_calibrate_and_smooth #(
   parameter int WINDOW_LEN = 8,
   parameter int CAL_FRAMES = 100
) (
   input  logic                               clock,
   input  logic                               reset,
   imu_scs_req_if.sink                        req_bus,
   imu_scs_rsp_if.source                      rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [imu_scs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imu_scs_pkg::CSR_DATA_W-1:0] csr_data
);

   `include "imu_sample_calibrate_and_smooth_macros.svh"

   localparam int CH         = imu_scs_pkg::CHANNELS;
   localparam int MOTION_CH  = imu_scs_pkg::MOTION_CH;
   localparam int MAG_CH     = imu_scs_pkg::MAG_CH;
   localparam int DATA_W     = imu_scs_pkg::DATA_W;
   localparam int SENS_W     = imu_scs_pkg::SENS_W;
   localparam int MAG_PROD_W = imu_scs_pkg::MAG_PROD_W;
   localparam int MAG_SHIFT  = imu_scs_pkg::MAG_SHIFT;
   localparam int AW         = $clog2(WINDOW_LEN);
   localparam int WSUM_W     = DATA_W + $clog2(WINDOW_LEN);
   localparam int ROW_W      = $bits(imu_scs_pkg::sample_vec_type);
   localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_LEN - 1);

   // frame held in the read-modify-write stage
   typedef struct packed {
      imu_scs_pkg::motion_vec_type        motion;
      logic [MAG_CH-1:0][MAG_PROD_W-1:0]  mag_prod;
      logic                               mag_ok;
      logic [AW-1:0]                      pos;
      logic                               old_ok;
      imu_scs_pkg::item_flags_type        flags;
   } stage_a_type;

   // configuration
   logic [MAG_CH-1:0][SENS_W-1:0]   sens_ff;
   logic [MAG_CH-1:0][DATA_W-1:0]   moff_ff;

   // ring and stage state
   logic [AW-1:0]                   pos_ff, pos_in;
   logic                            full_ff;
   logic                            pos_wrap;
   logic                            a_valid_ff;
   stage_a_type                     a_ff, a_in;
   logic [CH-1:0][WSUM_W-1:0]       wsum_ff, wsum_in;
   logic [MAG_CH-1:0][DATA_W-1:0]   last_mag_ff;

   // handshakes
   logic                            req_fire;
   logic                            a_move;
   logic                            avg_in_ready;

   // datapath
   imu_scs_pkg::sample_vec_type     raw;
   imu_scs_pkg::motion_vec_type     motion_in;
   imu_scs_pkg::motion_vec_type     motion_off;
   imu_scs_pkg::cal_status_type     cal_status;
   logic [MAG_CH-1:0][DATA_W-1:0]   mag_new;
   imu_scs_pkg::sample_vec_type     v_all;
   imu_scs_pkg::sample_vec_type     old_row;
   logic [ROW_W-1:0]                mem_rd_data;

   assign req_fire          = req_bus.valid && req_bus.ready;
   assign a_move            = a_valid_ff && avg_in_ready;
   // the divider rewrites the offsets; frames wait for it
   assign req_bus.ready     = (!a_valid_ff || a_move) && !cal_status.busy;

   assign pos_wrap = (pos_ff == LAST_POS);
   assign pos_in   = pos_wrap ? '0 : pos_ff + 1'b1;

   // --- accept side: offsets, magnetometer gain product ---
   always_comb begin
      raw[0] = req_bus.data.acc_x;
      raw[1] = req_bus.data.acc_y;
      raw[2] = req_bus.data.acc_z;
      raw[3] = req_bus.data.gyro_x;
      raw[4] = req_bus.data.gyro_y;
      raw[5] = req_bus.data.gyro_z;
      raw[6] = req_bus.data.mag_x;
      raw[7] = req_bus.data.mag_y;
      raw[8] = req_bus.data.mag_z;
      for (int i = 0; i < MOTION_CH; i++) begin
         // accel Z offset already holds one g minus the rest average
         if (i == imu_scs_pkg::ACC_Z_LANE) begin
            motion_in[i] = raw[i] + motion_off[i];
         end else begin
            motion_in[i] = raw[i] - motion_off[i];
         end
      end
      a_in.motion = motion_in;
      for (int i = 0; i < MAG_CH; i++) begin
         a_in.mag_prod[i] = $signed(raw[MOTION_CH + i]) * $signed({1'b0, sens_ff[i]});
      end
      a_in.mag_ok = req_bus.data.mag_ready && !req_bus.data.mag_overrun
                    && !req_bus.data.mag_overflow;
      a_in.pos    = pos_ff;
      // rows are meaningful only once the ring has wrapped
      a_in.old_ok = full_ff;
      a_in.flags.full       = full_ff || pos_wrap;
      a_in.flags.calibrated = cal_status.done || cal_status.last;
   end

   imu_scs_cal #(
      .CAL_FRAMES (CAL_FRAMES)
   ) u_cal (
      .clock   (clock),
      .reset   (reset),
      .take    (req_fire),
      .motion  (motion_in),
      .offsets (motion_off),
      .status  (cal_status)
   );

   imu_scs_win_mem #(
      .DEPTH (WINDOW_LEN),
      .WIDTH (ROW_W)
   ) u_win_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (mem_rd_data),
      .wr_en   (a_move),
      .wr_addr (a_ff.pos),
      .wr_data (v_all)
   );

   // --- read-modify-write stage ---
   always_comb begin
      old_row = imu_scs_pkg::sample_vec_type'(mem_rd_data);
      for (int i = 0; i < MAG_CH; i++) begin
         // floor(prod / 256) wrapped to 16 bits is just the middle slice
         mag_new[i] = a_ff.mag_prod[i][MAG_SHIFT +: DATA_W] - moff_ff[i];
      end
      for (int i = 0; i < MOTION_CH; i++) begin
         v_all[i] = a_ff.motion[i];
      end
      for (int i = 0; i < MAG_CH; i++) begin
         v_all[MOTION_CH + i] = a_ff.mag_ok ? mag_new[i] : last_mag_ff[i];
      end
      for (int i = 0; i < CH; i++) begin
         wsum_in[i] = wsum_ff[i] + WSUM_W'($signed(v_all[i]));
         if (a_ff.old_ok) begin
            wsum_in[i] = wsum_in[i] - WSUM_W'($signed(old_row[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff     <= {MAG_CH{imu_scs_pkg::SENS_RESET}};
         moff_ff     <= '0;
         pos_ff      <= '0;
         full_ff     <= 1'b0;
         a_valid_ff  <= 1'b0;
         wsum_ff     <= '0;
         last_mag_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               imu_scs_pkg::CSR_MAG_SENS_X:   sens_ff[0] <= csr_data[SENS_W-1:0];
               imu_scs_pkg::CSR_MAG_SENS_Y:   sens_ff[1] <= csr_data[SENS_W-1:0];
               imu_scs_pkg::CSR_MAG_SENS_Z:   sens_ff[2] <= csr_data[SENS_W-1:0];
               imu_scs_pkg::CSR_MAG_OFFSET_X: moff_ff[0] <= csr_data[DATA_W-1:0];
               imu_scs_pkg::CSR_MAG_OFFSET_Y: moff_ff[1] <= csr_data[DATA_W-1:0];
               imu_scs_pkg::CSR_MAG_OFFSET_Z: moff_ff[2] <= csr_data[DATA_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_fire) begin
            pos_ff     <= pos_in;
            full_ff    <= full_ff || pos_wrap;
            a_valid_ff <= 1'b1;
         end else if (a_move) begin
            a_valid_ff <= 1'b0;
         end
         if (a_move) begin
            wsum_ff <= wsum_in;
            if (a_ff.mag_ok) begin
               last_mag_ff <= mag_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_ff <= a_in;
      end
   end

   // --- divide by the window length and result register ---
   imu_scs_avg #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_avg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_valid_ff),
      .in_ready   (avg_in_ready),
      .in_sums    (wsum_in),
      .in_samples (v_all),
      .in_flags   (a_ff.flags),
      .rsp        (rsp_bus)
   );

   // --- checks ---
   `IMU_ASSERT_IMPLY(a_no_take_while_div, clock, reset, cal_status.busy, !req_fire, "frame taken while offsets are being computed")
   `IMU_ASSERT_IMPLY(a_rmw_rows_apart, clock, reset, a_move && req_fire, a_ff.pos != pos_ff, "window read and write hit the same row")
   `IMU_ASSERT_IMPLY(a_calibrated_flag, clock, reset, rsp_bus.valid && rsp_bus.data.calibrated, cal_status.done, "calibrated flag ahead of calibration")
   `IMU_ASSERT_NEXT(a_ring_wrap, clock, reset, req_fire && pos_wrap, full_ff && (pos_ff == '0), "ring wrap not recorded")

endmodule

// ===== dv/imu_sample_calibrate_and_smooth_test.sv =====
// Self-checking testbench for the IMU calibrate and smooth block.
`timescale 1ns / 1ps

module imu_sample_calibrate_and_smooth_test;

   localparam int CHANNELS    = imu_scs_pkg::CHANNELS;
   localparam int MOTION_CH   = imu_scs_pkg::MOTION_CH;
   localparam int MAG_CH      = imu_scs_pkg::MAG_CH;
   localparam int DATA_W      = imu_scs_pkg::DATA_W;
   localparam int SENS_W      = imu_scs_pkg::SENS_W;
   localparam int MAG_SHIFT   = imu_scs_pkg::MAG_SHIFT;
   localparam int ACC_Z_LANE  = imu_scs_pkg::ACC_Z_LANE;
   localparam int CSR_IDX_W   = imu_scs_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = imu_scs_pkg::CSR_DATA_W;

   typedef imu_scs_pkg::sample_type sample_type;
   typedef imu_scs_pkg::req_type    req_type;
   typedef imu_scs_pkg::rsp_type    rsp_type;

   localparam int WINDOW      = 8;
   localparam int CAL_N       = 100;
   localparam int MAX_REPORTS = 40;
   localparam int TAIL_CYCLES = 12;   // margin for the stage A, p1, p2 and result registers
   // status bits in word order: ready, overrun, overflow
   localparam logic [2:0] MAG_GOOD = 3'b100;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   imu_scs_req_if req_bus ();
   imu_scs_rsp_if rsp_bus ();

   imu_sample_calibrate_and_smooth #(
      .WINDOW_LEN(WINDOW),
      .CAL_FRAMES(CAL_N)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------
   // Predictor state: mirrors the block after reset
   // ---------------------------------------------------------------------
   logic [SENS_W-1:0] mag_gain [MAG_CH] = '{default: imu_scs_pkg::SENS_RESET};
   sample_type mag_bias [MAG_CH]        = '{default: '0};
   sample_type held_mag [MAG_CH]        = '{default: '0};
   sample_type ring [CHANNELS][WINDOW]  = '{default: '{default: '0}};
   int         ring_sum [CHANNELS]      = '{default: 0};
   int         ring_pos                 = 0;
   bit         ring_full                = 1'b0;
   int         cal_frames_seen          = 0;
   int         cal_acc [MOTION_CH]      = '{default: 0};
   bit         cal_done_m               = 1'b0;
   sample_type motion_off [MOTION_CH]   = '{default: '0};

   rsp_type smoothed_due [$];

   int error_count     = 0;
   int results_seen    = 0;
   int burst_left      = 0;
   int rsp_hold_cycles = 0;
   rsp_type want_rsp;

   // One frame through correction, calibration and the window average.
   function automatic rsp_type calibrate_and_smooth(input req_type f);
      sample_type raw  [CHANNELS];
      sample_type corr [CHANNELS];
      sample_type avg  [CHANNELS];
      int prod;
      int mean;
      rsp_type r;
      raw = '{f.acc_x, f.acc_y, f.acc_z, f.gyro_x, f.gyro_y, f.gyro_z,
              f.mag_x, f.mag_y, f.mag_z};
      // accel Z carries 8192 - mean, so it is added rather than subtracted
      for (int i = 0; i < MOTION_CH; i++)
         corr[i] = (i == ACC_Z_LANE) ? raw[i] + motion_off[i] : raw[i] - motion_off[i];
      if (f.mag_ready && !f.mag_overrun && !f.mag_overflow) begin
         for (int i = 0; i < MAG_CH; i++) begin
            prod = int'(raw[MOTION_CH + i]) * int'({1'b0, mag_gain[i]});
            // arithmetic shift gives the floor the scaling needs
            held_mag[i] = sample_type'((prod >>> MAG_SHIFT) - int'(mag_bias[i]));
         end
      end
      for (int i = 0; i < MAG_CH; i++)
         corr[MOTION_CH + i] = held_mag[i];
      if (!cal_done_m) begin
         for (int i = 0; i < MOTION_CH; i++)
            cal_acc[i] += corr[i];
         cal_frames_seen++;
         if (cal_frames_seen >= CAL_N) begin
            for (int i = 0; i < MOTION_CH; i++) begin
               mean = cal_acc[i] / CAL_N;
               if (i == ACC_Z_LANE)
                  mean = int'(imu_scs_pkg::ONE_G_COUNTS) - mean;
               motion_off[i] = sample_type'(mean);
               cal_acc[i]    = 0;
            end
            cal_frames_seen = 0;
            cal_done_m      = 1'b1;
         end
      end
      for (int i = 0; i < CHANNELS; i++) begin
         ring_sum[i]       -= ring[i][ring_pos];
         ring[i][ring_pos]  = corr[i];
         ring_sum[i]       += corr[i];
      end
      ring_pos++;
      if (ring_pos >= WINDOW) begin
         ring_pos  = 0;
         ring_full = 1'b1;
      end
      // newest sample until the ring first wraps, then the truncated mean
      for (int i = 0; i < CHANNELS; i++)
         avg[i] = ring_full ? sample_type'(ring_sum[i] / WINDOW) : corr[i];
      r.avg_acc_x  = avg[0];
      r.avg_acc_y  = avg[1];
      r.avg_acc_z  = avg[2];
      r.avg_gyro_x = avg[3];
      r.avg_gyro_y = avg[4];
      r.avg_gyro_z = avg[5];
      r.avg_mag_x  = avg[6];
      r.avg_mag_y  = avg[7];
      r.avg_mag_z  = avg[8];
      r.calibrated = cal_done_m;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Frame builders
   // ---------------------------------------------------------------------
   function automatic sample_type near(input int centre, input int spread);
      return sample_type'(centre - spread + int'($urandom_range(0, 2 * spread)));
   endfunction

   function automatic req_type uniform_frame(input sample_type value,
                                             input logic [2:0] status);
      req_type f;
      f.acc_x  = value;
      f.acc_y  = value;
      f.acc_z  = value;
      f.gyro_x = value;
      f.gyro_y = value;
      f.gyro_z = value;
      f.mag_x  = value;
      f.mag_y  = value;
      f.mag_z  = value;
      {f.mag_ready, f.mag_overrun, f.mag_overflow} = status;
      return f;
   endfunction

   function automatic sample_type lane_value();
      return ($urandom_range(0, 1) == 0) ? sample_type'($urandom) : near(0, 3000);
   endfunction

   // mostly good magnetometer samples, the rest any status mix
   function automatic logic [2:0] random_status();
      return ($urandom_range(0, 3) != 0) ? MAG_GOOD : 3'($urandom);
   endfunction

   function automatic req_type random_frame();
      req_type f;
      f.acc_x  = lane_value();
      f.acc_y  = lane_value();
      f.acc_z  = lane_value();
      f.gyro_x = lane_value();
      f.gyro_y = lane_value();
      f.gyro_z = lane_value();
      f.mag_x  = lane_value();
      f.mag_y  = lane_value();
      f.mag_z  = lane_value();
      {f.mag_ready, f.mag_overrun, f.mag_overflow} = random_status();
      return f;
   endfunction

   // a unit at rest: small bias on each axis, about 1 g on accel Z
   function automatic req_type resting_frame();
      req_type f;
      f.acc_x  = near(300, 200);
      f.acc_y  = near(-450, 200);
      f.acc_z  = near(7900, 300);
      f.gyro_x = near(-40, 30);
      f.gyro_y = near(25, 30);
      f.gyro_z = near(-12, 30);
      f.mag_x  = near(1200, 400);
      f.mag_y  = near(-800, 400);
      f.mag_z  = near(400, 400);
      {f.mag_ready, f.mag_overrun, f.mag_overflow} = random_status();
      return f;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side: called at a falling edge, returns at one
   // ---------------------------------------------------------------------
   task automatic send_frame(input req_type f);
      req_bus.data  <= f;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      smoothed_due.push_back(calibrate_and_smooth(f));
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // bursts of random length, now and then a long unbroken one
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_sender($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (smoothed_due.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Register writes, only with nothing in flight
   // ---------------------------------------------------------------------
   task automatic write_reg(input imu_scs_pkg::csr_index_type idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      case (idx)
         imu_scs_pkg::CSR_MAG_SENS_X:   mag_gain[0] = value[SENS_W-1:0];
         imu_scs_pkg::CSR_MAG_SENS_Y:   mag_gain[1] = value[SENS_W-1:0];
         imu_scs_pkg::CSR_MAG_SENS_Z:   mag_gain[2] = value[SENS_W-1:0];
         imu_scs_pkg::CSR_MAG_OFFSET_X: mag_bias[0] = sample_type'(value);
         imu_scs_pkg::CSR_MAG_OFFSET_Y: mag_bias[1] = sample_type'(value);
         imu_scs_pkg::CSR_MAG_OFFSET_Z: mag_bias[2] = sample_type'(value);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(input int gain_x, input int gain_y, input int gain_z,
                            input int bias_x, input int bias_y, input int bias_z);
      drain();
      write_reg(imu_scs_pkg::CSR_MAG_SENS_X, gain_x);
      write_reg(imu_scs_pkg::CSR_MAG_SENS_Y, gain_y);
      write_reg(imu_scs_pkg::CSR_MAG_SENS_Z, gain_z);
      write_reg(imu_scs_pkg::CSR_MAG_OFFSET_X, bias_x);
      write_reg(imu_scs_pkg::CSR_MAG_OFFSET_Y, bias_y);
      write_reg(imu_scs_pkg::CSR_MAG_OFFSET_Z, bias_z);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Field extremes under extreme gains and offsets, so the scaled
   // magnetometer value wraps; then every status mix; then floor rounding
   // of negative products at unity gain.
   task automatic test_directed_extremes();
      req_type f;
      configure(383, 383, 383, -32768, 32767, -32768);
      send_frame(uniform_frame(16'sh0000, MAG_GOOD));
      repeat (3) send_frame(uniform_frame(16'sh7fff, MAG_GOOD));
      repeat (3) send_frame(uniform_frame(16'sh8000, MAG_GOOD));
      send_frame(uniform_frame(16'sh5555, MAG_GOOD));
      send_frame(uniform_frame(16'shaaaa, MAG_GOOD));
      send_frame(uniform_frame(-16'sd1, MAG_GOOD));
      configure(128, 128, 128, 32767, -32768, 1);
      for (int s = 0; s < 8; s++) begin
         f       = uniform_frame(sample_type'(s * 911 - 3000), 3'(s));
         f.mag_x = sample_type'(s * 4099 - 16000);
         f.mag_y = sample_type'(12000 - s * 3001);
         f.mag_z = sample_type'(s * 7 - 20);
         send_frame(f);
      end
      configure(256, 256, 256, 0, 0, 0);
      send_frame(uniform_frame(-16'sd1, MAG_GOOD));
      send_frame(uniform_frame(-16'sd255, MAG_GOOD));
      send_frame(uniform_frame(-16'sd257, MAG_GOOD));
      send_frame(uniform_frame(16'sd255, MAG_GOOD));
      idle_sender(1);
   endtask

   // Finish the startup average with a unit at rest, and keep offering
   // words through the divider stall that follows the last one.
   task automatic test_startup_calibration();
      while (!cal_done_m) begin
         send_frame(resting_frame());
         pace_sender();
      end
      repeat (20) send_frame(resting_frame());
      idle_sender(1);
   endtask

   task automatic test_register_sweep();
      int gains [5][3] = '{'{128, 128, 128}, '{383, 383, 383}, '{256, 256, 256},
                           '{129, 300, 382}, '{0, 0, 0}};
      int biases [5][3] = '{'{-32768, -32768, -32768}, '{32767, 32767, 32767},
                            '{0, 0, 0}, '{-1, 1, 12345}, '{0, 0, 0}};
      for (int p = 0; p < 5; p++) begin
         if (p == 4) begin
            // one setting drawn at random across the legal ranges
            for (int a = 0; a < MAG_CH; a++) begin
               gains[p][a]  = $urandom_range(128, 383);
               biases[p][a] = int'($urandom_range(0, 65535)) - 32768;
            end
         end
         configure(gains[p][0], gains[p][1], gains[p][2],
                   biases[p][0], biases[p][1], biases[p][2]);
         repeat (60) begin
            send_frame(random_frame());
            pace_sender();
         end
      end
      idle_sender(1);
   endtask

   // The receiver holds off for a long stretch while words keep coming,
   // so every stage fills and the input has to stall.
   task automatic test_output_backpressure();
      rsp_hold_cycles = 150;
      repeat (40) send_frame(random_frame());
      idle_sender(1);
   endtask

   task automatic test_random_traffic();
      repeat (520) begin
         send_frame(($urandom_range(0, 4) == 0) ? resting_frame() : random_frame());
         pace_sender();
      end
      idle_sender(1);
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: result word %0d: %s", $time, results_seen, what);
   endtask

   task automatic check_lane(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name,
                                   $signed(got), $signed(want)));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (smoothed_due.size() == 0) begin
            report_mismatch("word arrived with nothing expected");
         end else begin
            want_rsp = smoothed_due.pop_front();
            check_lane("avg_acc_x",  rsp_bus.data.avg_acc_x,  want_rsp.avg_acc_x);
            check_lane("avg_acc_y",  rsp_bus.data.avg_acc_y,  want_rsp.avg_acc_y);
            check_lane("avg_acc_z",  rsp_bus.data.avg_acc_z,  want_rsp.avg_acc_z);
            check_lane("avg_gyro_x", rsp_bus.data.avg_gyro_x, want_rsp.avg_gyro_x);
            check_lane("avg_gyro_y", rsp_bus.data.avg_gyro_y, want_rsp.avg_gyro_y);
            check_lane("avg_gyro_z", rsp_bus.data.avg_gyro_z, want_rsp.avg_gyro_z);
            check_lane("avg_mag_x",  rsp_bus.data.avg_mag_x,  want_rsp.avg_mag_x);
            check_lane("avg_mag_y",  rsp_bus.data.avg_mag_y,  want_rsp.avg_mag_y);
            check_lane("avg_mag_z",  rsp_bus.data.avg_mag_z,  want_rsp.avg_mag_z);
            check_lane("calibrated", DATA_W'(rsp_bus.data.calibrated),
                       DATA_W'(want_rsp.calibrated));
         end
         results_seen++;
      end
   end

   // ---------------------------------------------------------------------
   // Clock, receiver stalls, limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall pattern of its own: always ready, coin toss, mostly stalled or
   // ready on a periodic tick, each kept for a random stretch.
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      int tick;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("imu_sample_calibrate_and_smooth_test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      csr_wr_en     = 1'b0;
      csr_index     = imu_scs_pkg::CSR_MAG_SENS_X;
      csr_data      = '0;
      reset         = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_startup_calibration();
      test_register_sweep();
      test_output_backpressure();
      test_random_traffic();

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("imu_sample_calibrate_and_smooth_test passed");
      else
         $display("imu_sample_calibrate_and_smooth_test failed");
      $finish;
   end

endmodule
